// File: sv/rational_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// rational arithmetic unit assertion macros
// shared property wrappers for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_SUB  = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_DIV  = 3'd3;
  localparam logic [2:0] CMD_CMP  = 3'd4;
  localparam logic [2:0] CMD_NEG  = 3'd5;
  localparam logic [2:0] CMD_INV  = 3'd6;
  localparam logic [2:0] CMD_NORM = 3'd7;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZDEN = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

  localparam logic [1:0] CMPR_EQ = 2'd0;
  localparam logic [1:0] CMPR_GT = 2'd1;
  localparam logic [1:0] CMPR_LT = 2'd2;

  localparam logic [63:0] LIMIT_MAG = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {
    KIND_ZDEN,
    KIND_CMP,
    KIND_RED
  } kind_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] x_num;
    logic [30:0]        x_den;
    logic signed [31:0] y_num;
    logic [30:0]        y_den;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic [1:0]         cmp_out;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  cmp;
    logic        neg;
    logic [63:0] mag;
    logic [62:0] den;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: sv/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// fraction add, sub, mul, div, compare, negate, invert and normalise
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// while the front end registers the operands and cross-multiplies them, so
// a new word is not taken until the front end is through with the last one.
// The back end reduces the fraction with a binary gcd loop (one step a
// cycle, data dependent) followed by a shift-subtract divider that divides
// numerator and denominator together; compare results, zero numerators and
// zero-denominator words skip the loop and the divider and come out when
// the back end pops them from the queue while idle. Each result is shown
// for one cycle with out_valid high and cannot be held off by the receiver.
// A two-entry queue lets the next word be decoded while the back end is
// still reducing.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

`include "rational_arithmetic_unit_defines.svh"

  logic    front_active, push, pop;
  job_t    f_job, q_job;
  q_stat_t q_stat;

  assign busy = front_active | q_stat.full;

  rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (start & !busy),
    .in_word (in_word),
    .active  (front_active),
    .push    (push),
    .job     (f_job)
  );

  rau_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (f_job),
    .pop    (pop),
    .rd_job (q_job),
    .stat   (q_stat)
  );

  rau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .job       (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  `RAU_ASSERT_NOW(a_no_push_full, push, !q_stat.full, "word pushed into full queue")
  `RAU_ASSERT_NOW(a_den_nonzero, out_valid, out_word.res_den != '0, "zero denominator out")
  `RAU_ASSERT_NOW(a_flag_clean, out_valid && out_word.status != STAT_OK,
    out_word.res_num == '0 && out_word.res_den == 63'd1, "flagged result not 0/1")
  `RAU_ASSERT_NEXT(a_busy_after_take, start && !busy, busy, "busy not raised after take")

endmodule

// File: sv/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front
// decodes a word, cross-multiplies the operands and builds a reduction job
// ----------------------------------------------------------------------------
module rau_front import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_word_t in_word,
  output logic     active,
  output logic     push,
  output job_t     job
);

  localparam int SH = 32 - OPERAND_WIDTH;
  localparam logic [30:0] DEN_MASK = 31'((64'd1 << (OPERAND_WIDTH - 1)) - 64'd1);

  logic signed [31:0] xn_sh, yn_sh, xn32, yn32;
  logic signed [32:0] xn, yn, xd, yd, xn_abs, yn_abs;
  logic signed [32:0] a1, b1, a2, b2, a3, b3;
  logic               zd, negf;

  logic               va_r, vb_r;
  logic [2:0]         cmd_a_r, cmd_b_r;
  logic               zd_a_r, zd_b_r, neg_a_r, neg_b_r;
  logic signed [32:0] a1_r, b1_r, a2_r, b2_r, a3_r, b3_r;
  logic signed [63:0] m1_r, m2_r, m3_r;
  logic signed [63:0] s;
  logic [63:0]        s_mag;

  always_comb begin
    xn_sh  = in_word.x_num <<< SH;
    yn_sh  = in_word.y_num <<< SH;
    xn32   = xn_sh >>> SH;
    yn32   = yn_sh >>> SH;
    xn     = 33'(xn32);
    yn     = 33'(yn32);
    xd     = $signed({2'b00, in_word.x_den & DEN_MASK});
    yd     = $signed({2'b00, in_word.y_den & DEN_MASK});
    xn_abs = xn[32] ? -xn : xn;
    yn_abs = yn[32] ? -yn : yn;
    zd = (xd == '0) || ((in_word.cmd <= CMD_CMP) && (yd == '0))
      || ((in_word.cmd == CMD_DIV) && (yn == '0))
      || ((in_word.cmd == CMD_INV) && (xn == '0));
    a1 = xn; b1 = yd; a2 = '0; b2 = '0; a3 = xd; b3 = yd;
    negf = 1'b0;
    unique case (in_word.cmd)
      CMD_ADD, CMD_SUB, CMD_CMP: begin
        a2 = yn; b2 = xd;
      end
      CMD_MUL: begin
        a1 = xn_abs; b1 = yn_abs; negf = xn[32] ^ yn[32];
      end
      CMD_DIV: begin
        a1 = xn_abs; b1 = yd; a3 = xd; b3 = yn_abs; negf = xn[32] ^ yn[32];
      end
      CMD_NEG: begin
        a1 = xn_abs; b1 = 33'sd1; b3 = 33'sd1; negf = !xn[32] && (xn != '0);
      end
      CMD_INV: begin
        a1 = xd; b1 = 33'sd1; a3 = xn_abs; b3 = 33'sd1; negf = xn[32];
      end
      default: begin
        a1 = xn_abs; b1 = 33'sd1; b3 = 33'sd1; negf = xn[32];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= take;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_a_r <= in_word.cmd;
      zd_a_r  <= zd;
      neg_a_r <= negf;
      a1_r <= a1; b1_r <= b1;
      a2_r <= a2; b2_r <= b2;
      a3_r <= a3; b3_r <= b3;
    end
    if (va_r) begin
      cmd_b_r <= cmd_a_r;
      zd_b_r  <= zd_a_r;
      neg_b_r <= neg_a_r;
      m1_r <= 64'(a1_r * b1_r);
      m2_r <= 64'(a2_r * b2_r);
      m3_r <= 64'(a3_r * b3_r);
    end
  end

  always_comb begin
    s     = ((cmd_b_r == CMD_SUB) || (cmd_b_r == CMD_CMP)) ? m1_r - m2_r : m1_r + m2_r;
    s_mag = s[63] ? 64'(-s) : 64'(s);
    job.cmp = CMPR_EQ;
    if (s[63]) begin
      job.cmp = CMPR_LT;
    end else if (s != '0) begin
      job.cmp = CMPR_GT;
    end
    job.mag = s_mag;
    job.den = m3_r[62:0];
    job.neg = ((cmd_b_r == CMD_ADD) || (cmd_b_r == CMD_SUB)) ? s[63] : neg_b_r;
    priority if (zd_b_r) begin
      job.kind = KIND_ZDEN;
    end else if (cmd_b_r == CMD_CMP) begin
      job.kind = KIND_CMP;
    end else begin
      job.kind = KIND_RED;
    end
  end

  assign active = va_r | vb_r;
  assign push   = vb_r;

endmodule

// File: sv/rau_queue.sv
// ----------------------------------------------------------------------------
// rau_queue
// short job queue between the front and back ends
// ----------------------------------------------------------------------------
module rau_queue import rau_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    wr_job,
  input  logic    pop,
  output job_t    rd_job,
  output q_stat_t stat
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t            mem [QUEUE_DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assign rd_job     = mem[rp_r];
  assign stat.full  = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// File: sv/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back
// binary gcd, exact division of both parts and result formatting
// ----------------------------------------------------------------------------
module rau_back import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  job_t      job,
  output logic      pop,
  output logic      out_valid,
  output out_word_t out_word
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GCD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] a_r, b_r, g_r, nq_r, dq_r;
  logic [64:0] nr_r, dr_r;
  logic [6:0]  k_r;
  logic [5:0]  cnt_r;
  logic        neg_r;
  logic [64:0] nr_sh, dr_sh;
  logic        n_ge, d_ge;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty && job.kind == KIND_RED && job.mag != '0) begin
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (a_r == '0 || b_r == '0) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == '1) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign pop   = (state_r == S_IDLE) && !q_stat.empty;
  assign nr_sh = {nr_r[63:0], nq_r[63]};
  assign dr_sh = {dr_r[63:0], dq_r[63]};
  assign n_ge  = nr_sh >= {1'b0, g_r};
  assign d_ge  = dr_sh >= {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (pop && !(job.kind == KIND_RED && job.mag != '0)) || (state_r == S_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        a_r   <= job.mag;
        b_r   <= {1'b0, job.den};
        nq_r  <= job.mag;
        dq_r  <= {1'b0, job.den};
        neg_r <= job.neg;
        k_r   <= '0;
        out_word.res_num <= '0;
        out_word.res_den <= 63'd1;
        out_word.cmp_out <= (job.kind == KIND_CMP) ? job.cmp : CMPR_EQ;
        out_word.status  <= (job.kind == KIND_ZDEN) ? STAT_ZDEN : STAT_OK;
      end
      S_GCD: begin
        nr_r  <= '0;
        dr_r  <= '0;
        cnt_r <= '0;
        g_r   <= (a_r | b_r) << k_r;
        priority if (a_r == '0 || b_r == '0) begin
          a_r <= a_r;
        end else if (!a_r[0] && !b_r[0]) begin
          a_r <= a_r >> 1;
          b_r <= b_r >> 1;
          k_r <= k_r + 7'd1;
        end else if (!a_r[0]) begin
          a_r <= a_r >> 1;
        end else if (!b_r[0]) begin
          b_r <= b_r >> 1;
        end else if (a_r >= b_r) begin
          a_r <= a_r - b_r;
        end else begin
          b_r <= b_r - a_r;
        end
      end
      S_DIV: begin
        cnt_r <= cnt_r + 6'd1;
        nr_r  <= n_ge ? nr_sh - {1'b0, g_r} : nr_sh;
        dr_r  <= d_ge ? dr_sh - {1'b0, g_r} : dr_sh;
        nq_r  <= {nq_r[62:0], n_ge};
        dq_r  <= {dq_r[62:0], d_ge};
      end
      S_EMIT: begin
        if (nq_r > LIMIT_MAG) begin
          out_word.res_num <= '0;
          out_word.res_den <= 63'd1;
          out_word.status  <= STAT_OVF;
        end else begin
          out_word.res_num <= neg_r ? -$signed(nq_r) : $signed(nq_r);
          out_word.res_den <= dq_r[62:0];
          out_word.status  <= STAT_OK;
        end
        out_word.cmp_out <= CMPR_EQ;
      end
      default: ;
    endcase
  end

endmodule
